>>> hdl/adsr_pkg.sv
// adsr_pkg: shared types, stage codes, register indexes and reset values
// for the adsr envelope shaper; no dependencies
`default_nettype none

package adsr_pkg;

   // default widths
   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int LEVEL_FRAC_BITS_DEF = 24;

   // envelope stage codes
   localparam int STAGE_BITS = 3;
   typedef logic [STAGE_BITS-1:0] stage_type;
   localparam stage_type ST_ATTACK  = 3'd0;
   localparam stage_type ST_DECAY   = 3'd1;
   localparam stage_type ST_SUSTAIN = 3'd2;
   localparam stage_type ST_RELEASE = 3'd3;
   localparam stage_type ST_DONE    = 3'd4;

   // control register indexes
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_ATTACK_STEP   = 2'd0;
   localparam csr_index_type CSR_DECAY_STEP    = 2'd1;
   localparam csr_index_type CSR_SUSTAIN_LEVEL = 2'd2;
   localparam csr_index_type CSR_RELEASE_STEP  = 2'd3;

   // register reset values, as unsigned fractions of full scale
   localparam logic [31:0] ATTACK_STEP_RST   = 32'd1024;
   localparam logic [31:0] DECAY_STEP_RST    = 32'd512;
   localparam logic [31:0] SUSTAIN_LEVEL_RST = 32'd8388608;
   localparam logic [31:0] RELEASE_STEP_RST  = 32'd256;

   // user flag positions in the request tuser
   localparam int USER_KEY_DOWN = 0;
   localparam int USER_RESTART  = 1;
   localparam int USER_BITS     = 2;

endpackage : adsr_pkg

`default_nettype wire

>>> hdl/adsr_env_step.sv
// adsr_env_step: envelope stage and level registers with the per-sample
// update logic; depends on adsr_pkg
`default_nettype none

module adsr_env_step
   import adsr_pkg::*;
#(
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step_en,
   input  wire logic                       key_down,
   input  wire logic                       restart,
   input  wire logic [LEVEL_FRAC_BITS-1:0] attack_step,
   input  wire logic [LEVEL_FRAC_BITS-1:0] decay_step,
   input  wire logic [LEVEL_FRAC_BITS-1:0] sustain_level,
   input  wire logic [LEVEL_FRAC_BITS-1:0] release_step,
   output logic      [LEVEL_FRAC_BITS-1:0] level_next,
   output stage_type                       stage_next
);

   localparam int F = LEVEL_FRAC_BITS;
   // 0.999 of full scale, rounded half up
   localparam logic [63:0] CLAMP_WIDE = (64'd999 * (64'd1 << F) + 64'd500) / 64'd1000;
   localparam logic [F-1:0] LVL_CLAMP = CLAMP_WIDE[F-1:0];

   logic [F-1:0] level_ff;
   stage_type    stage_ff;
   logic [F-1:0] cur_level;
   stage_type    cur_stage;
   logic [F:0]   attack_sum;
   logic [F-1:0] decay_lvl;

   // restart acts before the step
   assign cur_level  = restart ? '0 : level_ff;
   assign cur_stage  = restart ? ST_ATTACK : stage_ff;
   assign attack_sum = {1'b0, cur_level} + {1'b0, attack_step};
   assign decay_lvl  = (decay_step >= cur_level) ? '0 : cur_level - decay_step;

   always_comb begin
      level_next = '0;
      stage_next = cur_stage;
      unique case (cur_stage)
         ST_ATTACK: begin
            if (attack_sum[F]) begin
               level_next = LVL_CLAMP;
               stage_next = ST_DECAY;
            end else begin
               level_next = attack_sum[F-1:0];
               stage_next = ST_ATTACK;
            end
            if (!key_down) stage_next = ST_RELEASE;
         end
         ST_DECAY: begin
            level_next = decay_lvl;
            stage_next = (decay_lvl <= sustain_level) ? ST_SUSTAIN : ST_DECAY;
            if (!key_down) stage_next = ST_RELEASE;
         end
         ST_SUSTAIN: begin
            level_next = sustain_level;
            stage_next = key_down ? ST_SUSTAIN : ST_RELEASE;
         end
         ST_RELEASE: begin
            if (release_step >= cur_level) begin
               level_next = '0;
               stage_next = ST_DONE;
            end else begin
               level_next = cur_level - release_step;
               stage_next = ST_RELEASE;
            end
         end
         default: begin
            // done and unused codes hold at zero
            level_next = '0;
            stage_next = cur_stage;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         stage_ff <= ST_ATTACK;
      end else if (step_en) begin
         level_ff <= level_next;
         stage_ff <= stage_next;
      end
   end

endmodule : adsr_env_step

`default_nettype wire

>>> hdl/adsr_scale.sv
// adsr_scale: multiplies the sample by the envelope level, floors by the
// fraction width and holds the result word; depends on adsr_pkg
`default_nettype none

module adsr_scale
   import adsr_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire logic                       unload,
   input  wire logic [SAMPLE_BITS-1:0]     sample_in,
   input  wire logic [LEVEL_FRAC_BITS-1:0] level_in,
   input  wire stage_type                  stage_in,
   output logic                            valid,
   output logic      [SAMPLE_BITS-1:0]     sample_out,
   output logic      [LEVEL_FRAC_BITS-1:0] level_out,
   output stage_type                       stage_out
);

   localparam int F = LEVEL_FRAC_BITS;
   localparam int P = SAMPLE_BITS + F + 1;

   logic signed [P-1:0]          product;
   logic                         valid_ff;
   logic [SAMPLE_BITS-1:0]       sample_ff;
   logic [F-1:0]                 level_ff;
   stage_type                    stage_ff;

   // signed sample times unsigned level; the slice is the floored shift
   assign product = $signed({{(F+1){sample_in[SAMPLE_BITS-1]}}, sample_in})
                  * $signed({{SAMPLE_BITS{1'b0}}, 1'b0, level_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (unload) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= product[F +: SAMPLE_BITS];
         level_ff  <= level_in;
         stage_ff  <= stage_in;
      end
   end

   assign valid      = valid_ff;
   assign sample_out = sample_ff;
   assign level_out  = level_ff;
   assign stage_out  = stage_ff;

endmodule : adsr_scale

`default_nettype wire

>>> hdl/adsr_envelope_shaper_top.sv
// adsr_envelope_shaper_top: top level of the linear adsr envelope shaper
// depends on adsr_pkg, adsr_env_step and adsr_scale
`default_nettype none

// Linear attack/decay/sustain/release envelope applied to a sample stream.
// Each request word carries one signed sample plus the key_down and restart
// flags; each response word carries the scaled sample, the new envelope level
// (unsigned fraction, LEVEL_FRAC_BITS bits) and the stage code. The block
// takes one word per clock cycle while the response side is not stalled and
// answers each with exactly one word. The rate is set by the envelope update:
// stage and level are updated at the acceptance edge into the first-stage
// registers, and the multiply sits in the following stage in front of the
// response register. Slopes and the sustain level are to be written through
// the csr port while the stream is idle; the block does not enforce this.
// csr_wdata has exactly the level width.
module adsr_envelope_shaper_top
   import adsr_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF,
   localparam int REQ_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_FIELD_BITS = SAMPLE_BITS + LEVEL_FRAC_BITS + STAGE_BITS,
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request stream
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]   req_tdata,  // sample_in, zero pad
   input  wire logic [USER_BITS-1:0]       req_tuser,  // key_down, restart
   // response stream
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]   rsp_tdata,  // sample_out, level, stage, zero pad
   // control register writes
   input  wire logic                       csr_we,
   input  wire csr_index_type              csr_index,
   input  wire logic [LEVEL_FRAC_BITS-1:0] csr_wdata
);

   localparam int F = LEVEL_FRAC_BITS;
   localparam int S = SAMPLE_BITS;

   // control registers
   logic [F-1:0] attack_step_ff;
   logic [F-1:0] decay_step_ff;
   logic [F-1:0] sustain_level_ff;
   logic [F-1:0] release_step_ff;

   // first stage: updated envelope and the sample waiting for the multiply
   logic         s1_valid_ff;
   logic [S-1:0] s1_sample_ff;
   logic [F-1:0] s1_level_ff;
   stage_type    s1_stage_ff;

   logic         req_accept;
   logic         out_ready;
   logic         s1_ready;
   logic         out_load;
   logic [F-1:0] level_next;
   stage_type    stage_next;
   logic [S-1:0] rsp_sample;
   logic [F-1:0] rsp_level;
   stage_type    rsp_stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff   <= F'(ATTACK_STEP_RST);
         decay_step_ff    <= F'(DECAY_STEP_RST);
         sustain_level_ff <= F'(SUSTAIN_LEVEL_RST);
         release_step_ff  <= F'(RELEASE_STEP_RST);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ATTACK_STEP:   attack_step_ff   <= csr_wdata;
            CSR_DECAY_STEP:    decay_step_ff    <= csr_wdata;
            CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata;
            CSR_RELEASE_STEP:  release_step_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // each stage takes a word when it is empty or passing its own word on
   assign out_ready  = !rsp_tvalid || rsp_tready;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_tready = s1_ready;
   assign req_accept = req_tvalid && req_tready;
   assign out_load   = s1_valid_ff && out_ready;

   // envelope advances exactly once per accepted word
   adsr_env_step #(
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_env_step (
      .clock         (clock),
      .reset         (reset),
      .step_en       (req_accept),
      .key_down      (req_tuser[USER_KEY_DOWN]),
      .restart       (req_tuser[USER_RESTART]),
      .attack_step   (attack_step_ff),
      .decay_step    (decay_step_ff),
      .sustain_level (sustain_level_ff),
      .release_step  (release_step_ff),
      .level_next    (level_next),
      .stage_next    (stage_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_tdata[S-1:0];
         s1_level_ff  <= level_next;
         s1_stage_ff  <= stage_next;
      end
   end

   // multiply and response register
   adsr_scale #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .unload     (rsp_tready),
      .sample_in  (s1_sample_ff),
      .level_in   (s1_level_ff),
      .stage_in   (s1_stage_ff),
      .valid      (rsp_tvalid),
      .sample_out (rsp_sample),
      .level_out  (rsp_level),
      .stage_out  (rsp_stage)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_stage, rsp_level, rsp_sample});

endmodule : adsr_envelope_shaper_top

`default_nettype wire

>>> test/adsr_envelope_shaper_top_tb.sv
// adsr_envelope_shaper_top_tb: self-checking bench for the adsr envelope shaper
// needs adsr_pkg and the adsr_envelope_shaper_top rtl; predicts every response
// word in a scoreboard class and compares it field by field
`default_nettype none

module adsr_envelope_shaper_top_tb
   import adsr_pkg::*;
;

   // widths follow the package defaults the block is built with
   localparam int SB    = SAMPLE_BITS_DEF;
   localparam int LB    = LEVEL_FRAC_BITS_DEF;
   localparam int REQ_W = ((SB + 7) / 8) * 8;
   localparam int RSP_W = ((SB + LB + STAGE_BITS + 7) / 8) * 8;

   // 0.999 of full scale, rounded half up
   localparam longint        LEVEL_ONE   = longint'(1) << LB;
   localparam logic [LB-1:0] LEVEL_CLAMP = LB'((999 * LEVEL_ONE + 500) / 1000);
   localparam logic [LB-1:0] LEVEL_MAX   = '1;

   localparam logic [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   localparam int DRAIN_CYCLES   = 8;     // idle wait after the last response comes back
   localparam int WATCHDOG_LIMIT = 5000;  // cycles without any handshake or write
   localparam int REPORT_CAP     = 200;   // keep the log short on a broken build

   typedef struct packed {
      logic [SB-1:0] sample;
      logic [LB-1:0] level;
      stage_type     stage;
   } env_word_type;

   // envelope predictor and store of predicted response words
   class envelope_checker;
      logic [LB-1:0] attack_step;
      logic [LB-1:0] decay_step;
      logic [LB-1:0] sustain_level;
      logic [LB-1:0] release_step;
      logic [LB-1:0] env_level;
      stage_type     env_stage;
      env_word_type  predicted[$];
      int            mismatches;
      int            words_seen;

      function new();
         attack_step   = ATTACK_STEP_RST[LB-1:0];
         decay_step    = DECAY_STEP_RST[LB-1:0];
         sustain_level = SUSTAIN_LEVEL_RST[LB-1:0];
         release_step  = RELEASE_STEP_RST[LB-1:0];
         env_level     = '0;
         env_stage     = ST_ATTACK;
         mismatches    = 0;
         words_seen    = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [LB-1:0] value);
         case (idx)
            CSR_ATTACK_STEP:   attack_step   = value;
            CSR_DECAY_STEP:    decay_step    = value;
            CSR_SUSTAIN_LEVEL: sustain_level = value;
            CSR_RELEASE_STEP:  release_step  = value;
            default: ;
         endcase
      endfunction

      // advance the envelope by one accepted sample and queue its response
      function void note_sample(logic [SB-1:0] sample, logic key_down, logic restart);
         logic [LB:0]    sum;
         longint signed  prod;
         env_word_type   w;
         if (restart) begin
            env_level = '0;
            env_stage = ST_ATTACK;
         end
         case (env_stage)
            ST_ATTACK: begin
               sum = {1'b0, env_level} + {1'b0, attack_step};
               if (sum[LB]) begin
                  env_level = LEVEL_CLAMP;
                  env_stage = ST_DECAY;
               end else begin
                  env_level = sum[LB-1:0];
               end
               if (!key_down) env_stage = ST_RELEASE;
            end
            ST_DECAY: begin
               env_level = (decay_step >= env_level) ? '0 : env_level - decay_step;
               if (env_level <= sustain_level) env_stage = ST_SUSTAIN;
               if (!key_down) env_stage = ST_RELEASE;
            end
            ST_SUSTAIN: begin
               env_level = sustain_level;
               if (!key_down) env_stage = ST_RELEASE;
            end
            ST_RELEASE: begin
               if (release_step >= env_level) begin
                  env_level = '0;
                  env_stage = ST_DONE;
               end else begin
                  env_level = env_level - release_step;
               end
            end
            default: env_level = '0;
         endcase
         // signed sample times unsigned level, floor shift
         prod     = $signed(sample) * $signed({1'b0, env_level});
         prod     = prod >>> LB;
         w.sample = prod[SB-1:0];
         w.level  = env_level;
         w.stage  = env_stage;
         predicted.push_back(w);
      endfunction

      task report(string field, longint got, longint want);
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("mismatch on response word %0d, %s: got 0x%0h, want 0x%0h",
                     words_seen, field, got, want);
      endtask

      task check_word(logic [RSP_W-1:0] data);
         env_word_type got;
         env_word_type want;
         got.sample = data[SB-1:0];
         got.level  = data[SB+LB-1:SB];
         got.stage  = data[SB+LB+STAGE_BITS-1:SB+LB];
         if (predicted.size() == 0) begin
            report("word with none predicted", longint'(data), 0);
         end else begin
            want = predicted.pop_front();
            if (got.sample !== want.sample)
               report("sample_out", longint'(got.sample), longint'(want.sample));
            if (got.level !== want.level)
               report("level", longint'(got.level), longint'(want.level));
            if (got.stage !== want.stage)
               report("stage", longint'(got.stage), longint'(want.stage));
         end
         words_seen++;
      endtask

      function int outstanding();
         return predicted.size();
      endfunction
   endclass

   // dut inputs, all driven to known values from time zero
   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [USER_BITS-1:0] req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b1;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we     = 1'b0;
   csr_index_type    csr_index  = CSR_ATTACK_STEP;
   logic [LB-1:0]    csr_wdata  = '0;

   envelope_checker  envelope;
   int               send_idle_pct = 0;   // chance of a gap before each request word
   int               stall_pct     = 0;   // chance of rsp_tready low per cycle
   int               items_sent    = 0;
   int               quiet_cycles  = 0;

   adsr_envelope_shaper_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // sample both channels at the rising edge; the outputs come from registers
   // and from rsp_tready, so the values read here are the ones that meet at this edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) envelope.check_word(rsp_tdata);
         if (req_tvalid && req_tready)
            envelope.note_sample(req_tdata[SB-1:0], req_tuser[USER_KEY_DOWN],
                                 req_tuser[USER_RESTART]);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_we)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: a hung handshake ends the run
   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clock);
      $display("adsr_envelope_shaper_top regression: fail");
      $finish;
   end

   // offer one request word, with a random gap in front of it; called and
   // returns at a falling edge
   task automatic send_word(logic [SB-1:0] sample, logic key_down, logic restart);
      logic [USER_BITS-1:0] user;
      user                = '0;
      user[USER_KEY_DOWN] = key_down;
      user[USER_RESTART]  = restart;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sample);
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   // stop offering words and wait until every predicted word has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (envelope.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write all four registers back to back; only while the stream is idle
   task automatic write_config(logic [LB-1:0] attack, logic [LB-1:0] decay,
                               logic [LB-1:0] sustain, logic [LB-1:0] rel);
      csr_we    <= 1'b1;
      csr_index <= CSR_ATTACK_STEP;
      csr_wdata <= attack;
      @(negedge clock);
      csr_index <= CSR_DECAY_STEP;
      csr_wdata <= decay;
      @(negedge clock);
      csr_index <= CSR_SUSTAIN_LEVEL;
      csr_wdata <= sustain;
      @(negedge clock);
      csr_index <= CSR_RELEASE_STEP;
      csr_wdata <= rel;
      @(negedge clock);
      csr_we    <= 1'b0;
      envelope.set_reg(CSR_ATTACK_STEP, attack);
      envelope.set_reg(CSR_DECAY_STEP, decay);
      envelope.set_reg(CSR_SUSTAIN_LEVEL, sustain);
      envelope.set_reg(CSR_RELEASE_STEP, rel);
   endtask

   // slopes: mostly 2 to 64 samples for a full-scale ramp, sometimes the extremes
   function automatic logic [LB-1:0] pick_step();
      case ($urandom_range(0, 9))
         0: return LB'(1);
         1: return LEVEL_MAX;
         2: return '0;
         default: return LB'($urandom_range(32'h0004_0000, 32'h0080_0000));
      endcase
   endfunction

   function automatic logic [LB-1:0] pick_sustain();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LEVEL_MAX;
         2: return LEVEL_CLAMP;
         default: return LB'($urandom);
      endcase
   endfunction

   // one note: restart, key held, then a tail with the key mostly released
   task automatic play_note();
      int hold;
      int tail;
      hold = $urandom_range(1, 40);
      tail = $urandom_range(1, 24);
      for (int i = 0; i < hold; i++) begin
         // an occasional restart in mid note breaks the sequence
         send_word(SB'($urandom), 1'b1, (i == 0) || ($urandom_range(0, 49) == 0));
      end
      for (int i = 0; i < tail; i++) begin
         // key flag is meaningless once in release, toggle it anyway
         send_word(SB'($urandom), $urandom_range(0, 3) == 0, 1'b0);
      end
   endtask

   task automatic run_segment(int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) == 0)
            send_word(SB'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else
            play_note();
      end
   endtask

   initial begin : stimulus
      envelope = new();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset slopes: rise, release, key ignored while releasing
      send_word(SAMPLE_MAX, 1'b1, 1'b1);
      send_word(SAMPLE_MIN, 1'b1, 1'b0);
      send_word('0, 1'b1, 1'b0);
      send_word('1, 1'b0, 1'b0);
      send_word(SB'(16'h5555), 1'b1, 1'b0);
      wait_idle();

      // largest slopes, smallest sustain: clamp at full scale, decay floors
      // at zero, release reaches done, restart together with key off
      write_config(LEVEL_MAX, LEVEL_MAX, LB'(1), LEVEL_MAX);
      send_word(SAMPLE_MAX, 1'b1, 1'b1);
      send_word(SAMPLE_MIN, 1'b1, 1'b0);
      send_word(SAMPLE_MIN, 1'b1, 1'b0);
      send_word(SB'(12345), 1'b1, 1'b0);
      send_word(SAMPLE_MIN, 1'b0, 1'b0);
      send_word(SAMPLE_MAX, 1'b1, 1'b0);
      send_word(SAMPLE_MIN, 1'b1, 1'b0);
      send_word(SAMPLE_MAX, 1'b0, 1'b1);
      wait_idle();

      // zero slopes and zero sustain: level stays put, release of zero is done
      write_config('0, '0, '0, '0);
      send_word(SAMPLE_MAX, 1'b1, 1'b1);
      send_word('1, 1'b1, 1'b0);
      send_word(SB'(100), 1'b0, 1'b0);
      send_word(SB'(-100), 1'b1, 1'b0);
      wait_idle();

      // sustain above the clamp value: decay ends on its first sample
      write_config(LB'(24'h80_0000), LB'(1), LEVEL_MAX, LB'(1));
      send_word(SAMPLE_MIN, 1'b1, 1'b1);
      send_word(SAMPLE_MAX, 1'b1, 1'b0);
      send_word(SAMPLE_MAX, 1'b1, 1'b0);
      send_word(SAMPLE_MIN, 1'b1, 1'b0);
      send_word(SAMPLE_MIN, 1'b0, 1'b0);
      send_word(SAMPLE_MAX, 1'b1, 1'b1);

      // random notes under each idling pattern, three settings per pattern
      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         for (int k = 0; k < 3; k++) begin
            wait_idle();
            write_config(pick_step(), pick_step(), pick_sustain(), pick_step());
            run_segment(125);
         end
      end

      wait_idle();
      if (envelope.mismatches == 0 && envelope.outstanding() == 0) begin
         $display("adsr_envelope_shaper_top regression: pass");
      end else begin
         $display("adsr_envelope_shaper_top regression: fail");
      end
      $finish;
   end

endmodule : adsr_envelope_shaper_top_tb

`default_nettype wire
